// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the framer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/ifs_pkg.sv -----
// ----------------------------------------------------------------------------
// ifs_pkg
// Types, register indexes, reset values and the stuffing function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ifs_pkg;

	localparam int unsigned NUM_REGS  = 7;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned NUM_SLOTS = 9;

	typedef enum logic [IDX_W-1:0] {
		REG_FLAG      = 3'd0,
		REG_ESCAPE    = 3'd1,
		REG_FLAG_SUB  = 3'd2,
		REG_ESC_SUB   = 3'd3,
		REG_ADDRESS   = 3'd4,
		REG_CTRL_ZERO = 3'd5,
		REG_CTRL_ONE  = 3'd6
	} reg_idx_t;

	localparam logic [7:0] RST_FLAG      = 8'd126;
	localparam logic [7:0] RST_ESCAPE    = 8'd125;
	localparam logic [7:0] RST_FLAG_SUB  = 8'd94;
	localparam logic [7:0] RST_ESC_SUB   = 8'd93;
	localparam logic [7:0] RST_ADDRESS   = 8'd3;
	localparam logic [7:0] RST_CTRL_ZERO = 8'd0;
	localparam logic [7:0] RST_CTRL_ONE  = 8'd64;

	localparam logic OP_PAYLOAD = 1'b0;
	localparam logic OP_ACK     = 1'b1;

	// byte slots of one request, in transmit order
	localparam int unsigned SLOT_OPEN  = 0;
	localparam int unsigned SLOT_ADDR  = 1;
	localparam int unsigned SLOT_CTRL  = 2;
	localparam int unsigned SLOT_HCHK  = 3;
	localparam int unsigned SLOT_DAT0  = 4;
	localparam int unsigned SLOT_DAT1  = 5;
	localparam int unsigned SLOT_CHK0  = 6;
	localparam int unsigned SLOT_CHK1  = 7;
	localparam int unsigned SLOT_CLOSE = 8;

	typedef struct packed {
		logic [7:0] flag;
		logic [7:0] escape;
		logic [7:0] flag_sub;
		logic [7:0] esc_sub;
		logic [7:0] address;
		logic [7:0] ctrl_zero;
		logic [7:0] ctrl_one;
	} cfg_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0]      mask;
		logic [NUM_SLOTS-1:0][7:0] bytes;
	} run_t;

	typedef struct packed {
		logic       dbl;
		logic [7:0] b0;
		logic [7:0] b1;
	} stuff_t;

	// flag takes precedence where flag and escape coincide
	function automatic stuff_t stuff(input logic [7:0] b, input cfg_t c);
		stuff_t s;
		s.dbl = 1'b0;
		s.b0  = b;
		s.b1  = c.esc_sub;
		if (b == c.flag) begin
			s.dbl = 1'b1;
			s.b0  = c.escape;
			s.b1  = c.flag_sub;
		end else if (b == c.escape) begin
			s.dbl = 1'b1;
			s.b0  = c.escape;
			s.b1  = c.esc_sub;
		end
		return s;
	endfunction

endpackage

// ----- sv/ifs_if.sv -----
// ----------------------------------------------------------------------------
// ifs_item_if / ifs_result_if
// Valid/ready channels for input requests and framed output bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ifs_item_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] data_byte;
	logic       frame_last;
	logic       ack_number;

	modport source (output valid, operation, data_byte, frame_last, ack_number,
		input ready);
	modport sink (input valid, operation, data_byte, frame_last, ack_number,
		output ready);
endinterface

interface ifs_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;

	modport source (output valid, out_byte, run_last, frame_end, input ready);
	modport sink (input valid, out_byte, run_last, frame_end, output ready);
endinterface

// ----- sv/ifs_build.sv -----
// ----------------------------------------------------------------------------
// ifs_build
// Register file, frame state and per-request byte run construction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifs_build (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [ifs_pkg::IDX_W-1:0] wr_index,
	input  logic [7:0]                wr_data,
	input  logic                      accept,
	input  logic                      operation,
	input  logic [7:0]                data_byte,
	input  logic                      frame_last,
	input  logic                      ack_number,
	output ifs_pkg::run_t             run
);

	ifs_pkg::cfg_t   cfg_q;
	logic            seq_q;
	logic            in_frame_q;
	logic [7:0]      check_q;
	logic [7:0]      ctrl;
	logic [7:0]      check_nxt;
	ifs_pkg::stuff_t sd;
	ifs_pkg::stuff_t sc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag      <= ifs_pkg::RST_FLAG;
			cfg_q.escape    <= ifs_pkg::RST_ESCAPE;
			cfg_q.flag_sub  <= ifs_pkg::RST_FLAG_SUB;
			cfg_q.esc_sub   <= ifs_pkg::RST_ESC_SUB;
			cfg_q.address   <= ifs_pkg::RST_ADDRESS;
			cfg_q.ctrl_zero <= ifs_pkg::RST_CTRL_ZERO;
			cfg_q.ctrl_one  <= ifs_pkg::RST_CTRL_ONE;
		end else if (wr_en) begin
			case (ifs_pkg::reg_idx_t'(wr_index))
				ifs_pkg::REG_FLAG:      cfg_q.flag      <= wr_data;
				ifs_pkg::REG_ESCAPE:    cfg_q.escape    <= wr_data;
				ifs_pkg::REG_FLAG_SUB:  cfg_q.flag_sub  <= wr_data;
				ifs_pkg::REG_ESC_SUB:   cfg_q.esc_sub   <= wr_data;
				ifs_pkg::REG_ADDRESS:   cfg_q.address   <= wr_data;
				ifs_pkg::REG_CTRL_ZERO: cfg_q.ctrl_zero <= wr_data;
				ifs_pkg::REG_CTRL_ONE:  cfg_q.ctrl_one  <= wr_data;
				default: ;
			endcase
		end
	end

	assign ctrl      = seq_q ? cfg_q.ctrl_one : cfg_q.ctrl_zero;
	assign check_nxt = (in_frame_q ? check_q : 8'd0) ^ data_byte;
	assign sd        = ifs_pkg::stuff(data_byte, cfg_q);
	assign sc        = ifs_pkg::stuff(check_nxt, cfg_q);

	always_comb begin
		run.mask  = '0;
		run.bytes = '0;
		run.mask[ifs_pkg::SLOT_OPEN]   = !in_frame_q;
		run.mask[ifs_pkg::SLOT_ADDR]   = !in_frame_q;
		run.mask[ifs_pkg::SLOT_CTRL]   = !in_frame_q;
		run.mask[ifs_pkg::SLOT_HCHK]   = !in_frame_q;
		run.mask[ifs_pkg::SLOT_DAT0]   = 1'b1;
		run.mask[ifs_pkg::SLOT_DAT1]   = sd.dbl;
		run.mask[ifs_pkg::SLOT_CHK0]   = frame_last;
		run.mask[ifs_pkg::SLOT_CHK1]   = frame_last && sc.dbl;
		run.mask[ifs_pkg::SLOT_CLOSE]  = frame_last;
		run.bytes[ifs_pkg::SLOT_OPEN]  = cfg_q.flag;
		run.bytes[ifs_pkg::SLOT_ADDR]  = cfg_q.address;
		run.bytes[ifs_pkg::SLOT_CTRL]  = ctrl;
		run.bytes[ifs_pkg::SLOT_HCHK]  = cfg_q.address ^ ctrl;
		run.bytes[ifs_pkg::SLOT_DAT0]  = sd.b0;
		run.bytes[ifs_pkg::SLOT_DAT1]  = sd.b1;
		run.bytes[ifs_pkg::SLOT_CHK0]  = sc.b0;
		run.bytes[ifs_pkg::SLOT_CHK1]  = sc.b1;
		run.bytes[ifs_pkg::SLOT_CLOSE] = cfg_q.flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= 1'b0;
			in_frame_q <= 1'b0;
			check_q    <= 8'd0;
		end else if (accept) begin
			if (operation == ifs_pkg::OP_ACK) begin
				if (ack_number != seq_q) begin
					seq_q <= ~seq_q;
				end
			end else begin
				in_frame_q <= !frame_last;
				check_q    <= frame_last ? 8'd0 : check_nxt;
			end
		end
	end

endmodule

// ----- sv/ifs_ser.sv -----
// ----------------------------------------------------------------------------
// ifs_ser
// Run register and output register; emits one byte per cycle while result.ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifs_ser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  ifs_pkg::run_t run,
	output logic          slot_free,
	ifs_result_if.source  result
);

	ifs_pkg::run_t                  run_q;
	logic                           run_v_q;
	logic                           out_v_q;
	logic [7:0]                     byte_q;
	logic                           last_q;
	logic                           end_q;
	logic [ifs_pkg::NUM_SLOTS-1:0]  pick;
	logic [ifs_pkg::NUM_SLOTS-1:0]  rest;
	logic [7:0]                     pick_byte;
	logic                           pop;

	// lowest pending slot goes next
	assign pick = run_q.mask & (~run_q.mask + 1'b1);
	assign rest = run_q.mask & ~pick;

	always_comb begin
		pick_byte = 8'd0;
		for (int i = 0; i < ifs_pkg::NUM_SLOTS; i++) begin
			pick_byte = pick_byte | (run_q.bytes[i] & {8{pick[i]}});
		end
	end

	assign pop       = run_v_q && (!out_v_q || result.ready);
	assign slot_free = !run_v_q || (pop && rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				run_v_q <= 1'b1;
			end else if (pop) begin
				run_v_q <= rest != '0;
			end
			if (pop) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= run;
		end else if (pop) begin
			run_q.mask <= rest;
		end
		if (pop) begin
			byte_q <= pick_byte;
			last_q <= rest == '0;
			end_q  <= pick[ifs_pkg::SLOT_CLOSE];
		end
	end

	assign result.valid     = out_v_q;
	assign result.out_byte  = byte_q;
	assign result.run_last  = last_q;
	assign result.frame_end = end_q;

endmodule

// ----- sv/info_frame_stuffing_framer_core.sv -----
// ----------------------------------------------------------------------------
// info_frame_stuffing_framer_core: framed, byte-stuffed stream builder
// First byte of a request passes the run register, then the output register;
// one byte/cycle while result.ready is high. A payload request yields 1 to 9
// output bytes; an ack yields no byte.
// Async reset clears frame state, valids and restores register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module info_frame_stuffing_framer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [ifs_pkg::IDX_W-1:0] wr_index,
	input  logic [7:0]                wr_data,
	ifs_item_if.sink                  item,
	ifs_result_if.source              result
);

	ifs_pkg::run_t run;
	logic          slot_free;
	logic          accept;
	logic          load;

	assign item.ready = slot_free;
	assign accept     = item.valid && slot_free;
	assign load       = accept && item.operation == ifs_pkg::OP_PAYLOAD;

	ifs_build u_build (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.accept     (accept),
		.operation  (item.operation),
		.data_byte  (item.data_byte),
		.frame_last (item.frame_last),
		.ack_number (item.ack_number),
		.run        (run)
	);

	ifs_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.run       (run),
		.slot_free (slot_free),
		.result    (result)
	);

endmodule

// ----- sv/ifs_checker.sv -----
// ----------------------------------------------------------------------------
// ifs_checker
// Port-level checks on the framer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ifs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       item_operation,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_byte,
	input logic       res_last,
	input logic       res_end
);

	`ASSERT_CLK(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_byte), "result dropped or changed while stalled")
	`ASSERT_CLK(a_end_last, res_valid && res_end |-> res_last, "closing flag not last of its run")
	`ASSERT_CLK(a_payload_out, item_valid && item_ready && !item_operation |-> ##2 res_valid, "accepted payload produced no byte")
	`ASSERT_RST(a_rst_quiet, !arst_n |-> !res_valid, "result valid during reset")

endmodule

bind info_frame_stuffing_framer_core ifs_checker u_ifs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.item_operation (item.operation),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_byte       (result.out_byte),
	.res_last       (result.run_last),
	.res_end        (result.frame_end)
);
